[design/btbq_pkg.sv]
// Shared types and constants for the bass/treble biquad cascade.
package btbq_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int PROD_W   = 32;
	localparam int ACC_W    = 35;
	localparam int FF_W     = 48;
	localparam int FB_W     = 32;
	localparam int CFG_W    = 48;
	localparam int IDX_W    = 2;
	localparam int TAP_W    = 3;

	localparam logic [IDX_W-1:0] REG_BASS_FF   = 2'd0;
	localparam logic [IDX_W-1:0] REG_BASS_FB   = 2'd1;
	localparam logic [IDX_W-1:0] REG_TREBLE_FF = 2'd2;
	localparam logic [IDX_W-1:0] REG_TREBLE_FB = 2'd3;

	localparam logic [FF_W-1:0] FF_RESET = 48'd8192;
	localparam logic [FB_W-1:0] FB_RESET = 32'd0;

	localparam logic [TAP_W-1:0] TAP_B0  = 3'd0;
	localparam logic [TAP_W-1:0] TAP_B1  = 3'd1;
	localparam logic [TAP_W-1:0] TAP_B2  = 3'd2;
	localparam logic [TAP_W-1:0] TAP_A1  = 3'd3;
	localparam logic [TAP_W-1:0] TAP_A2  = 3'd4;
	localparam logic [TAP_W-1:0] TAP_FIN = 3'd5;

	localparam logic SEC_BASS   = 1'b0;
	localparam logic SEC_TREBLE = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	typedef struct packed {
		logic             load;
		logic             clear;
		logic             step;
		logic             sec;
		logic [TAP_W-1:0] tap;
	} btbq_cmd_t;

endpackage

[design/btbq_dp.sv]
// Datapath: coefficient registers, section histories and shared multiply-accumulate.
module btbq_dp import btbq_pkg::*; #(
	parameter int COEF_FRAC_BITS = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  btbq_cmd_t                  cmd,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       clipped
);

	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'sd1 << (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SAT_MAX);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SAT_MIN);

	logic [FF_W-1:0] bass_ff_q, treble_ff_q;
	logic [FB_W-1:0] bass_fb_q, treble_fb_q;

	logic signed [SAMPLE_W-1:0] bass_xh_q [2];
	logic signed [SAMPLE_W-1:0] bass_yh_q [2];
	logic signed [SAMPLE_W-1:0] treble_xh_q [2];
	logic signed [SAMPLE_W-1:0] treble_yh_q [2];

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       clip_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       clipped_q;

	logic [FF_W-1:0]            ff;
	logic [FB_W-1:0]            fb;
	logic signed [SAMPLE_W-1:0] xh0, xh1, yh0, yh1;
	logic signed [COEF_W-1:0]   coef;
	logic signed [SAMPLE_W-1:0] data;
	logic signed [PROD_W-1:0]   prod_d;
	logic signed [ACC_W-1:0]    sum_d;
	logic signed [ACC_W-1:0]    shifted;
	logic                       sat_hi, sat_lo, sat;
	logic signed [SAMPLE_W-1:0] y_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bass_ff_q   <= FF_RESET;
			bass_fb_q   <= FB_RESET;
			treble_ff_q <= FF_RESET;
			treble_fb_q <= FB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASS_FF:   bass_ff_q   <= cfg_data[FF_W-1:0];
				REG_BASS_FB:   bass_fb_q   <= cfg_data[FB_W-1:0];
				REG_TREBLE_FF: treble_ff_q <= cfg_data[FF_W-1:0];
				REG_TREBLE_FB: treble_fb_q <= cfg_data[FB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cmd.sec == SEC_TREBLE) begin
			ff  = treble_ff_q;
			fb  = treble_fb_q;
			xh0 = treble_xh_q[0];
			xh1 = treble_xh_q[1];
			yh0 = treble_yh_q[0];
			yh1 = treble_yh_q[1];
		end else begin
			ff  = bass_ff_q;
			fb  = bass_fb_q;
			xh0 = bass_xh_q[0];
			xh1 = bass_xh_q[1];
			yh0 = bass_yh_q[0];
			yh1 = bass_yh_q[1];
		end
		case (cmd.tap)
			TAP_B0: begin
				coef = ff[15:0];
				data = x_q;
			end
			TAP_B1: begin
				coef = ff[31:16];
				data = xh0;
			end
			TAP_B2: begin
				coef = ff[47:32];
				data = xh1;
			end
			TAP_A1: begin
				coef = fb[15:0];
				data = yh0;
			end
			TAP_A2: begin
				coef = fb[31:16];
				data = yh1;
			end
			default: begin
				coef = '0;
				data = '0;
			end
		endcase
	end

	assign prod_d  = PROD_W'(coef) * PROD_W'(data);
	assign sum_d   = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign shifted = sum_d >>> COEF_FRAC_BITS;
	assign sat_hi  = shifted > ACC_MAX;
	assign sat_lo  = shifted < ACC_MIN;
	assign sat     = sat_hi | sat_lo;
	assign y_d     = sat_hi ? SAT_MAX : (sat_lo ? SAT_MIN : shifted[SAMPLE_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= sample_in;
			clip_q <= 1'b0;
			if (cmd.clear) begin
				bass_xh_q   <= '{default: '0};
				bass_yh_q   <= '{default: '0};
				treble_xh_q <= '{default: '0};
				treble_yh_q <= '{default: '0};
			end
		end
		if (cmd.step) begin
			prod_q <= prod_d;
			if (cmd.tap == TAP_B0) begin
				acc_q <= HALF;
			end else begin
				acc_q <= sum_d;
			end
			if (cmd.tap == TAP_FIN) begin
				x_q    <= y_d;
				clip_q <= clip_q | sat;
				if (cmd.sec == SEC_TREBLE) begin
					treble_xh_q[1] <= treble_xh_q[0];
					treble_xh_q[0] <= x_q;
					treble_yh_q[1] <= treble_yh_q[0];
					treble_yh_q[0] <= y_d;
					sample_out_q   <= y_d;
					clipped_q      <= clip_q | sat;
				end else begin
					bass_xh_q[1] <= bass_xh_q[0];
					bass_xh_q[0] <= x_q;
					bass_yh_q[1] <= bass_yh_q[0];
					bass_yh_q[0] <= y_d;
				end
			end
		end
	end

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

[design/btbq_ctrl.sv]
// Controller: handshakes, block position and the tap sequence of both sections.
module btbq_ctrl import btbq_pkg::*; #(
	parameter int BLOCK_SAMPLES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_ready,
	output logic      result_valid,
	input  logic      result_ready,
	output btbq_cmd_t cmd
);

	localparam int POS_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_SAMPLES - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic             sec_q;
	logic [TAP_W-1:0] tap_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;

	logic accept, last, slot_free, step;

	assign accept    = sample_valid && (state_q == ST_IDLE);
	assign last      = (sec_q == SEC_TREBLE) && (tap_q == TAP_FIN);
	assign slot_free = !out_valid_q || result_ready;
	assign step      = (state_q == ST_RUN) && (!last || slot_free);

	always_comb begin
		cmd.load  = accept;
		cmd.clear = (pos_q == '0);
		cmd.step  = step;
		cmd.sec   = sec_q;
		cmd.tap   = tap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sec_q       <= SEC_BASS;
			tap_q       <= TAP_B0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_RUN;
				sec_q   <= SEC_BASS;
				tap_q   <= TAP_B0;
				pos_q   <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
			end
			if (step) begin
				if (tap_q == TAP_FIN) begin
					tap_q <= TAP_B0;
					if (sec_q == SEC_TREBLE) begin
						state_q <= ST_IDLE;
					end else begin
						sec_q <= SEC_TREBLE;
					end
				end else begin
					tap_q <= tap_q + TAP_W'(1);
				end
			end
			if (step && last) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

endmodule

[design/bass_treble_biquad_cascade.sv]
// Top level of the bass/treble biquad cascade equalizer.
// Usage:
//   Input channel sample_valid/sample_ready carries one signed 16-bit sample
//   per transaction; output channel result_valid/result_ready carries the
//   equalized sample and clip flag, one result per sample. Coefficients go
//   via cfg_we/cfg_index/cfg_data; write them only while idle (not enforced).
// Schedule:
//   One multiplier is shared by both sections: five products and one
//   round/saturate step per section, each step taken in turn.
//   The result is registered on the final treble step, and a new sample is
//   taken only once the previous one has gone through both sections.
// Reset:
//   Coefficients return to unity gain (b0 = 1.0, all others zero), the block
//   position returns to zero, and all histories are cleared on the first
//   sample of each block.
// Stall:
//   A result waits in the output register; the next sample is still taken and
//   worked on, and its final step holds until the output register is free.
module bass_treble_biquad_cascade import btbq_pkg::*; #(
	parameter int BLOCK_SAMPLES  = 1024,
	parameter int COEF_FRAC_BITS = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       clipped
);

	btbq_cmd_t cmd;

	btbq_ctrl #(
		.BLOCK_SAMPLES(BLOCK_SAMPLES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd)
	);

	btbq_dp #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_in (sample_in),
		.cmd       (cmd),
		.sample_out(sample_out),
		.clipped   (clipped)
	);

endmodule

[design/btbq_chk.sv]
// Port-level checker for the biquad cascade, bound to the top level.
module btbq_chk import btbq_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       sample_valid,
	input logic                       sample_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic signed [SAMPLE_W-1:0] sample_out,
	input logic                       clipped
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(sample_out) && $stable(clipped))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while busy");

	a_busy_through_work: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |-> ##12 !sample_ready)
		else $error("block idle before work done");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared without work");

endmodule

bind bass_treble_biquad_cascade btbq_chk u_chk (.*);
